// ===== rtl/sample_voice_mixer_unit_defines.svh =====
`ifndef SAMPLE_VOICE_MIXER_UNIT_DEFINES_SVH
`define SAMPLE_VOICE_MIXER_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk, off during rst
`define SVM_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("svm check failed");

// next-cycle implication, checked on clk, off during rst
`define SVM_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("svm check failed");

`endif

// ===== rtl/svm_pkg.sv =====
`timescale 1ns / 1ps

package svm_pkg;

  localparam int VOICE_COUNT  = 8;
  localparam int SAMPLE_WORDS = 65536;

  localparam int VIDX_W  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int SADDR_W = $clog2(SAMPLE_WORDS);
  localparam int ACC_W   = 22 + VIDX_W;
  localparam int ENDED_W = 8;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_PLAY   = 3'd2;
  localparam logic [2:0] OP_PAUSE  = 3'd3;
  localparam logic [2:0] OP_RESUME = 3'd4;
  localparam logic [2:0] OP_STOP   = 3'd5;

  typedef struct packed {
    logic [2:0]         op;
    logic [2:0]         voice;
    logic [15:0]        address;
    logic signed [15:0] sample;
    logic [15:0]        start_req;
    logic [15:0]        length;
    logic [15:0]        frame_count;
    logic [15:0]        gain;
    logic               stereo;
  } req_t;

  typedef struct packed {
    logic               is_frame;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [7:0]         ended_mask;
  } rsp_t;

  typedef struct packed {
    logic              apply;
    logic              fetch;
    logic              fetch_right;
    logic              finish_voice;
    logic              acc_left;
    logic              acc_right;
    logic              load_out;
    logic              out_frame;
    logic [VIDX_W-1:0] voice;
  } cmd_t;

  typedef struct packed {
    logic playing;
    logic at_end;
    logic stereo;
  } sts_t;

endpackage

// ===== rtl/svm_if.sv =====
`timescale 1ns / 1ps

interface svm_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic [2:0]         voice;
  logic [15:0]        address;
  logic signed [15:0] sample;
  logic [15:0]        start_req;
  logic [15:0]        length;
  logic [15:0]        frame_count;
  logic [15:0]        gain;
  logic               stereo;

  modport source (
    output valid, op, voice, address, sample, start_req, length, frame_count, gain, stereo,
    input  ready
  );
  modport sink (
    input  valid, op, voice, address, sample, start_req, length, frame_count, gain, stereo,
    output ready
  );
endinterface

interface svm_rsp_if;
  logic               valid;
  logic               ready;
  logic               is_frame;
  logic signed [15:0] left;
  logic signed [15:0] right;
  logic [7:0]         ended_mask;

  modport source (
    output valid, is_frame, left, right, ended_mask,
    input  ready
  );
  modport sink (
    input  valid, is_frame, left, right, ended_mask,
    output ready
  );
endinterface

// ===== rtl/svm_ram.sv =====
`timescale 1ns / 1ps

module svm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/svm_ctrl.sv =====
`timescale 1ns / 1ps

module svm_ctrl
  import svm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [2:0] req_op,
  output logic       req_ready,
  input  logic       rsp_ready,
  output logic       rsp_valid,
  input  sts_t       sts,
  output cmd_t       cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_VISIT = 3'd1;
  localparam logic [2:0] S_RDL   = 3'd2;
  localparam logic [2:0] S_ACCL  = 3'd3;
  localparam logic [2:0] S_ACCR  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(VOICE_COUNT - 1);

  logic [2:0]        state, state_next;
  logic [VIDX_W-1:0] voice, voice_next;
  logic              tick, tick_next;
  logic              rsp_valid_next;
  logic              advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      voice     <= '0;
      tick      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      voice     <= voice_next;
      tick      <= tick_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    voice_next = voice;
    tick_next  = tick;
    advance    = 1'b0;
    req_ready  = 1'b0;
    cmd        = '0;
    cmd.voice  = voice;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.apply = 1'b1;
          if (req_op == OP_TICK) begin
            tick_next  = 1'b1;
            voice_next = '0;
            state_next = S_VISIT;
          end else begin
            tick_next  = 1'b0;
            state_next = S_FIN;
          end
        end
      end
      S_VISIT: begin
        if (!sts.playing) begin
          advance = 1'b1;
        end else if (sts.at_end) begin
          cmd.finish_voice = 1'b1;
          advance          = 1'b1;
        end else begin
          cmd.fetch  = 1'b1;
          state_next = S_RDL;
        end
      end
      S_RDL: begin
        cmd.fetch_right = sts.stereo;
        state_next      = S_ACCL;
      end
      S_ACCL: begin
        cmd.acc_left  = 1'b1;
        cmd.acc_right = !sts.stereo;
        if (sts.stereo) begin
          state_next = S_ACCR;
        end else begin
          advance = 1'b1;
        end
      end
      S_ACCR: begin
        cmd.acc_right = 1'b1;
        advance       = 1'b1;
      end
      S_FIN: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.load_out  = 1'b1;
          cmd.out_frame = tick;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (advance) begin
      if (voice == LAST_VOICE) begin
        state_next = S_FIN;
      end else begin
        voice_next = voice + 1'b1;
        state_next = S_VISIT;
      end
    end
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.load_out) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

endmodule

// ===== rtl/svm_datapath.sv =====
`timescale 1ns / 1ps

module svm_datapath
  import svm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  output rsp_t rsp
);

  logic [15:0] base   [VOICE_COUNT];
  logic [15:0] cursor [VOICE_COUNT];
  logic [15:0] endp   [VOICE_COUNT];
  logic [15:0] gain   [VOICE_COUNT];
  logic        stereo [VOICE_COUNT];
  logic        playing[VOICE_COUNT];

  logic [15:0]        base_k, cursor_k, endp_k, gain_k;
  logic               stereo_k;
  logic [VIDX_W-1:0]  vidx;
  logic               vok;
  logic [16:0]        end_sum;
  logic [15:0]        end_new;
  logic [17:0]        addr_wide;
  logic [SADDR_W-1:0] raddr, ram_addr;
  logic               ram_we;
  logic [15:0]        ram_rdata;
  logic signed [32:0] prod, biased;
  logic signed [20:0] scaled;
  logic signed [ACC_W-1:0] lsum, rsum;
  logic [ENDED_W-1:0] ended;

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [15:0] r;
    if (v > ACC_W'(32767)) begin
      r = 16'sd32767;
    end else if (v < -ACC_W'(32767)) begin
      r = -16'sd32767;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  assign base_k   = base[cmd.voice];
  assign cursor_k = cursor[cmd.voice];
  assign endp_k   = endp[cmd.voice];
  assign gain_k   = gain[cmd.voice];
  assign stereo_k = stereo[cmd.voice];

  assign sts.playing = playing[cmd.voice];
  assign sts.at_end  = cursor_k >= endp_k;
  assign sts.stereo  = stereo_k;

  assign vidx    = VIDX_W'(req.voice);
  assign vok     = 32'(req.voice) < VOICE_COUNT;
  assign end_sum = {1'b0, req.start_req} + {1'b0, req.length};

  always_comb begin
    if (req.length == 16'd0 || req.length > req.frame_count) begin
      end_new = req.frame_count;
    end else if (end_sum[16]) begin
      end_new = 16'hFFFF;
    end else begin
      end_new = end_sum[15:0];
    end
  end

  // frame address, wrapped to the sample memory
  assign addr_wide = {2'b00, base_k} + (stereo_k ? {1'b0, cursor_k, 1'b0} : {2'b00, cursor_k});

  assign ram_we = cmd.apply && req.op == OP_WRITE;

  always_comb begin
    if (ram_we) begin
      ram_addr = SADDR_W'(req.address);
    end else if (cmd.fetch) begin
      ram_addr = SADDR_W'(addr_wide);
    end else begin
      ram_addr = raddr + 1'b1;
    end
  end

  svm_ram #(
    .WIDTH (16),
    .DEPTH (SAMPLE_WORDS)
  ) u_samples (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (req.sample),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      raddr <= SADDR_W'(addr_wide);
    end
    prod <= $signed(ram_rdata) * $signed({1'b0, gain_k});
  end

  // divide by 4096 rounding toward zero
  assign biased = prod[32] ? prod + 33'sd4095 : prod;
  assign scaled = $signed(biased[32:12]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
        base[i]    <= '0;
        cursor[i]  <= '0;
        endp[i]    <= '0;
        gain[i]    <= '0;
        stereo[i]  <= 1'b0;
        playing[i] <= 1'b0;
      end
    end else if (cmd.apply) begin
      unique case (req.op)
        OP_PLAY: begin
          if (vok) begin
            base[vidx]    <= req.address;
            cursor[vidx]  <= req.start_req;
            endp[vidx]    <= end_new;
            gain[vidx]    <= req.gain;
            stereo[vidx]  <= req.stereo;
            playing[vidx] <= 1'b1;
          end
        end
        OP_PAUSE: begin
          if (vok) begin
            playing[vidx] <= 1'b0;
          end
        end
        OP_RESUME: begin
          if (vok) begin
            playing[vidx] <= 1'b1;
          end
        end
        OP_STOP: begin
          if (vok) begin
            playing[vidx] <= 1'b0;
            cursor[vidx]  <= '0;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.fetch) begin
      cursor[cmd.voice] <= cursor_k + 16'd1;
    end else if (cmd.finish_voice) begin
      playing[cmd.voice] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && req.op == OP_TICK) begin
      lsum  <= '0;
      rsum  <= '0;
      ended <= '0;
    end else begin
      if (cmd.acc_left) begin
        lsum <= lsum + ACC_W'(scaled);
      end
      if (cmd.acc_right) begin
        rsum <= rsum + ACC_W'(scaled);
      end
      if (cmd.finish_voice) begin
        ended <= ended | (ENDED_W'(1) << cmd.voice);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (cmd.out_frame) begin
        rsp.is_frame   <= 1'b1;
        rsp.left       <= sat16(lsum);
        rsp.right      <= sat16(rsum);
        rsp.ended_mask <= ended;
      end else begin
        rsp <= '0;
      end
    end
  end

endmodule

// ===== rtl/sample_voice_mixer_unit.sv =====
// Eight-voice sample playback mixer over a 64K-word sample memory.
// req channel: one item per op (tick, write sample, play, pause, resume,
// stop); accepted when req.valid and req.ready are both high.
// rsp channel: exactly one item per request, in request order; a tick
// returns the saturated left/right mix and the ended mask, every other
// op returns an all-zero item with is_frame low.
// The block takes one item at a time: req.ready is high only while idle.
// A non-tick item is applied on accept and reaches the result register from the finish state.
// A tick walks the voices in order through one multiplier and the single
// sample memory port: an idle or ending voice is only visited, a mono voice
// adds read and accumulate steps, a stereo voice a second accumulate step.
// The result register decouples the sides: a new item is accepted while
// the previous result still waits; if rsp.ready stays low the block holds
// the next result and does not return to idle until it is taken.
// rst (synchronous) idles all voices and clears their settings; the
// sample memory is not cleared and holds nothing useful until written.
`timescale 1ns / 1ps
`include "sample_voice_mixer_unit_defines.svh"

module sample_voice_mixer_unit
  import svm_pkg::*;
(
  input logic         clk,
  input logic         rst,
  svm_req_if.sink     req,
  svm_rsp_if.source   rsp
);

  req_t req_pl;
  rsp_t rsp_pl;
  cmd_t cmd;
  sts_t sts;

  assign req_pl.op          = req.op;
  assign req_pl.voice       = req.voice;
  assign req_pl.address     = req.address;
  assign req_pl.sample      = req.sample;
  assign req_pl.start_req   = req.start_req;
  assign req_pl.length      = req.length;
  assign req_pl.frame_count = req.frame_count;
  assign req_pl.gain        = req.gain;
  assign req_pl.stereo      = req.stereo;

  svm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.op),
    .req_ready (req.ready),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  svm_datapath u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req_pl),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp_pl)
  );

  assign rsp.is_frame   = rsp_pl.is_frame;
  assign rsp.left       = rsp_pl.left;
  assign rsp.right      = rsp_pl.right;
  assign rsp.ended_mask = rsp_pl.ended_mask;

  `SVM_CHECK(a_load_slot_free, cmd.load_out, !rsp.valid || rsp.ready)
  `SVM_CHECK_NEXT(a_frame_out, cmd.load_out && cmd.out_frame, rsp.valid && rsp.is_frame)
  `SVM_CHECK(a_fetch_live_voice, cmd.fetch, sts.playing && !sts.at_end)
  `SVM_CHECK(a_nonframe_zero, rsp.valid && !rsp.is_frame,
             rsp.left == 16'sd0 && rsp.right == 16'sd0 && rsp.ended_mask == 8'd0)

endmodule
